// ===== rtl/core/transport_frame_header_checker_defines.svh =====
// Assertion macros shared by the transport frame header checker RTL.
// Included by the top level; relies on clk and arst_n being in scope.
`ifndef TRANSPORT_FRAME_HEADER_CHECKER_DEFINES_SVH
`define TRANSPORT_FRAME_HEADER_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define TFHC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define TFHC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tfhc_pkg.sv =====
// Shared types, constants and the CRC byte function for the frame header checker.
// No dependencies; imported by every module of the block.
package tfhc_pkg;

	// Frame format constants
	localparam logic [7:0]  START_BYTE   = 8'h7E;
	localparam logic [7:0]  VERSION_ONE  = 8'h01;
	localparam logic [15:0] CRC_POLY     = 16'h1021;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [7:0]  MIN_HDR_LEN  = 8'd12;
	localparam logic [16:0] POS_MAX      = 17'h1FFFF;
	localparam logic [4:0]  OPT_BASE     = 5'd10;
	localparam logic [4:0]  OPT_END      = 5'd20;

	// Result queue geometry
	localparam int unsigned QDEPTH = 8;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = QPTR_W + 1;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_SHORT       = 4'd1,
		ST_START       = 4'd2,
		ST_VERSION     = 4'd3,
		ST_HDRLEN      = 4'd4,
		ST_SIZE        = 4'd5,
		ST_CRC         = 4'd6,
		ST_SEG_NO_ID   = 4'd7,
		ST_SEG_NO_CNT  = 4'd8
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	// One result item
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		status_t     status;
		logic [7:0]  app_protocol;
		logic [3:0]  present_mask;
		logic [15:0] message_counter;
		logic [31:0] source_client_id;
		logic [15:0] data_id;
		logic [15:0] segment_count;
		logic [15:0] payload_len;
		logic        last;
	} res_t;

	// Up to two results produced by one byte, r0 goes out first
	typedef struct packed {
		logic [1:0] num;
		res_t       r0;
		res_t       r1;
	} push_t;

	// CRC-16, MSB first, one byte per call
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/tfhc_parser.sv =====
// Frame parser: per-frame header state, header CRC and the per-byte results.
// Depends on tfhc_pkg for constants, result types and crc_byte.
module tfhc_parser
	import tfhc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vld,
	input  logic [7:0]  rx_byte,
	input  logic        frame_end,
	output push_t       push
);

	logic [16:0] pos_q, pos_n;
	logic [7:0]  hlen_q, hlen_n;
	logic [15:0] plen_q, plen_n;
	logic [7:0]  proto_q, proto_n;
	logic [7:0]  flags_q, flags_n;
	logic [1:0]  sv_q, sv_n;
	logic [15:0] crc_q, crc_n;
	logic [15:0] crc_rx_q, crc_rx_n;
	logic [15:0] cnt_q, cnt_n;
	logic [31:0] client_q, client_n;
	logic [15:0] dataid_q, dataid_n;
	logic [15:0] seg_q, seg_n;

	logic [17:0] p18;
	logic [17:0] hl18;
	logic [4:0]  p5;
	logic [4:0]  off1, off2, off3;
	logic        in_opt;
	logic [3:0]  opt_len;
	logic        hl_ok;
	logic        fwd;
	logic [17:0] frame_len;
	logic [17:0] exp_len;
	status_t     st;
	res_t        pay_r, ver_r;

	// Next state for one byte
	always_comb begin
		pos_n    = pos_q;
		hlen_n   = hlen_q;
		plen_n   = plen_q;
		proto_n  = proto_q;
		flags_n  = flags_q;
		sv_n     = sv_q;
		crc_n    = crc_q;
		crc_rx_n = crc_rx_q;
		cnt_n    = cnt_q;
		client_n = client_q;
		dataid_n = dataid_q;
		seg_n    = seg_q;

		p18  = {1'b0, pos_q};
		p5   = pos_q[4:0];

		// fixed header bytes
		if (pos_q == 17'd0 && rx_byte == START_BYTE) sv_n[0] = 1'b1;
		if (pos_q == 17'd1 && rx_byte == VERSION_ONE) sv_n[1] = 1'b1;
		if (pos_q == 17'd2) hlen_n = rx_byte;
		if (pos_q == 17'd3) plen_n = {rx_byte, 8'h00};
		if (pos_q == 17'd4) plen_n = {plen_q[15:8], rx_byte};
		if (pos_q == 17'd5) proto_n = rx_byte;
		if (pos_q == 17'd9) flags_n = rx_byte;

		// optional fields packed from offset 10 in flag order
		in_opt = (pos_q >= 17'(OPT_BASE)) && (pos_q < 17'(OPT_END));
		off1 = OPT_BASE + (flags_q[0] ? 5'd2 : 5'd0);
		off2 = off1 + (flags_q[3] ? 5'd4 : 5'd0);
		off3 = off2 + (flags_q[5] ? 5'd2 : 5'd0);
		if (in_opt) begin
			if (flags_q[0] && p5 >= OPT_BASE && p5 < off1)
				cnt_n = {cnt_q[7:0], rx_byte};
			if (flags_q[3] && p5 >= off1 && p5 < off2)
				client_n = {client_q[23:0], rx_byte};
			if (flags_q[5] && p5 >= off2 && p5 < off3)
				dataid_n = {dataid_q[7:0], rx_byte};
			if (flags_q[6] && p5 >= off3 && p5 < off3 + 5'd2)
				seg_n = {seg_q[7:0], rx_byte};
		end

		// header CRC, then the two received CRC bytes
		hl18 = {10'd0, hlen_n};
		if (pos_q < 17'd3 || p18 + 18'd2 < hl18)
			crc_n = crc_byte(crc_q, rx_byte);
		else if (p18 + 18'd2 == hl18)
			crc_rx_n = {rx_byte, 8'h00};
		else if (p18 + 18'd1 == hl18)
			crc_rx_n = {crc_rx_q[15:8], rx_byte};

		// saturating position
		if (pos_q < POS_MAX) pos_n = pos_q + 17'd1;
	end

	// Header checks and payload window
	always_comb begin
		opt_len = (flags_n[0] ? 4'd2 : 4'd0) + (flags_n[3] ? 4'd4 : 4'd0)
			+ (flags_n[5] ? 4'd2 : 4'd0) + (flags_n[6] ? 4'd2 : 4'd0);
		hl_ok = ({1'b0, hlen_n} == 9'(MIN_HDR_LEN) + 9'(opt_len));
		fwd = (pos_q >= 17'd12) && (sv_n == 2'b11) && hl_ok
			&& (p18 >= hl18) && (p18 < hl18 + {2'b00, plen_n});
		frame_len = p18 + 18'd1;
		exp_len = hl18 + {2'b00, plen_n} + (flags_n[2] ? 18'd0 : 18'd2);

		priority if (frame_len < 18'(MIN_HDR_LEN)) st = ST_SHORT;
		else if (!sv_n[0])                          st = ST_START;
		else if (!sv_n[1])                          st = ST_VERSION;
		else if (!hl_ok)                            st = ST_HDRLEN;
		else if (frame_len != exp_len)              st = ST_SIZE;
		else if (crc_rx_n != crc_n)                 st = ST_CRC;
		else if (flags_n[6] && !flags_n[5])         st = ST_SEG_NO_ID;
		else if (flags_n[6] && !flags_n[0])         st = ST_SEG_NO_CNT;
		else                                        st = ST_OK;
	end

	// Result items for this byte
	always_comb begin
		pay_r = '0;
		pay_r.kind = KIND_PAYLOAD;
		pay_r.payload_byte = rx_byte;

		ver_r = '0;
		ver_r.kind = KIND_VERDICT;
		ver_r.status = st;
		ver_r.last = 1'b1;
		if (st == ST_OK) begin
			ver_r.app_protocol     = proto_n;
			ver_r.present_mask     = {flags_n[6], flags_n[5], flags_n[3], flags_n[0]};
			ver_r.message_counter  = cnt_n;
			ver_r.source_client_id = client_n;
			ver_r.data_id          = dataid_n;
			ver_r.segment_count    = seg_n;
			ver_r.payload_len      = plen_n;
		end

		push = '0;
		if (vld) begin
			priority if (fwd && frame_end) begin
				push.num = 2'd2;
				push.r0  = pay_r;
				push.r1  = ver_r;
			end else if (fwd) begin
				push.num = 2'd1;
				push.r0  = pay_r;
			end else if (frame_end) begin
				push.num = 2'd1;
				push.r0  = ver_r;
			end else begin
				push.num = 2'd0;
			end
		end
	end

	// Frame state; the final byte returns everything to the reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			hlen_q   <= '0;
			plen_q   <= '0;
			proto_q  <= '0;
			flags_q  <= '0;
			sv_q     <= '0;
			crc_q    <= CRC_INIT;
			crc_rx_q <= '0;
			cnt_q    <= '0;
			client_q <= '0;
			dataid_q <= '0;
			seg_q    <= '0;
		end else if (vld && frame_end) begin
			pos_q    <= '0;
			hlen_q   <= '0;
			plen_q   <= '0;
			proto_q  <= '0;
			flags_q  <= '0;
			sv_q     <= '0;
			crc_q    <= CRC_INIT;
			crc_rx_q <= '0;
			cnt_q    <= '0;
			client_q <= '0;
			dataid_q <= '0;
			seg_q    <= '0;
		end else if (vld) begin
			pos_q    <= pos_n;
			hlen_q   <= hlen_n;
			plen_q   <= plen_n;
			proto_q  <= proto_n;
			flags_q  <= flags_n;
			sv_q     <= sv_n;
			crc_q    <= crc_n;
			crc_rx_q <= crc_rx_n;
			cnt_q    <= cnt_n;
			client_q <= client_n;
			dataid_q <= dataid_n;
			seg_q    <= seg_n;
		end
	end

endmodule

// ===== rtl/core/tfhc_res_queue.sv =====
// Result queue: takes up to two result items per cycle, hands out one.
// Depends on tfhc_pkg for res_t, push_t and the queue geometry.
module tfhc_res_queue
	import tfhc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  push_t             push,
	input  logic              pop,
	output res_t              head,
	output logic              not_empty,
	output logic [QCNT_W-1:0] count
);

	res_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [QPTR_W-1:0] wr_next;

	assign wr_next   = wr_q + QPTR_W'(1);
	assign head      = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign count     = cnt_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push.num != 2'd0) mem_q[wr_q] <= push.r0;
		if (push.num == 2'd2) mem_q[wr_next] <= push.r1;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push.num);
			if (pop) rd_q <= rd_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(push.num) - QCNT_W'(pop);
		end
	end

endmodule

// ===== rtl/core/transport_frame_header_checker.sv =====
// Top level of the transport frame header checker: input register, parser, result queue.
// Depends on tfhc_pkg, tfhc_parser, tfhc_res_queue and the assertion macro header.
//
//  channel | dir | tdata                                    | tuser | tlast
//  s_      | in  | rx_byte                                  | -     | frame_end
//  m_      | out | payload_byte..payload_len (120 bits)     | kind  | last
//
// One byte per cycle is accepted while s_tready is high; its results enter the queue in the
// cycle after the input transaction, and the earliest output transaction for them is made from the queue head.
// A final byte inside the payload window yields two results (payload, verdict).
// s_tready drops when the queued results, plus two for a byte held in the input
// register, leave fewer than two free entries in the eight-entry queue.
// arst_n clears frame state and the queue; no clearing pass is needed.
`include "transport_frame_header_checker_defines.svh"

module transport_frame_header_checker
	import tfhc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] rx_byte
	input  logic         s_tlast,   // frame_end
	output logic         m_tvalid,
	input  logic         m_tready,
	// [7:0] payload_byte, [11:8] status, [19:12] app_protocol, [23:20] present_mask,
	// [39:24] message_counter, [71:40] source_client_id, [87:72] data_id,
	// [103:88] segment_count, [119:104] payload_len
	output logic [119:0] m_tdata,
	output logic         m_tuser,   // kind
	output logic         m_tlast    // last
);

	logic              vld_s1;
	logic [7:0]        byte_s1;
	logic              fin_s1;
	push_t             push;
	res_t              head;
	logic              not_empty;
	logic [QCNT_W-1:0] count;
	logic              pop;

	// Room check: results already queued plus two per byte still in the input stage
	assign s_tready = ({1'b0, count} + (vld_s1 ? (QCNT_W+1)'(2) : '0))
		<= (QCNT_W+1)'(QDEPTH - 2);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			fin_s1  <= s_tlast;
		end
	end

	tfhc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld       (vld_s1),
		.rx_byte   (byte_s1),
		.frame_end (fin_s1),
		.push      (push)
	);

	tfhc_res_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.count     (count)
	);

	// Output transaction
	assign pop      = not_empty && m_tready;
	assign m_tvalid = not_empty;
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;
	assign m_tdata  = {head.payload_len, head.segment_count, head.data_id,
		head.source_client_id, head.message_counter, head.present_mask,
		head.app_protocol, head.status, head.payload_byte};

	// Checks
	`TFHC_ASSERT_NOW(a_queue_room, vld_s1, count <= QCNT_W'(QDEPTH - 2), "queue overrun possible")
	`TFHC_ASSERT_NOW(a_pay_clean, m_tvalid && !m_tuser, !head.last && head.status == ST_OK, "bad payload")
	`TFHC_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, vld_s1, "accepted byte not registered")

endmodule

// ===== bench/transport_frame_header_checker_tb.sv =====
// Testbench for the transport frame header checker: sends byte streams of whole frames
// and compares each payload byte and verdict with a built-in frame parser.
// Depends on tfhc_pkg for the result and status types and the frame constants.
module transport_frame_header_checker_tb;
	import tfhc_pkg::*;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata  = 8'h00;
	logic         s_tlast  = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [119:0] m_tdata;
	logic         m_tuser;
	logic         m_tlast;

	// parser state, one frame at a time
	logic [16:0] rx_pos;
	logic [7:0]  hdr_len;
	logic [15:0] pay_len;
	logic [7:0]  proto;
	logic [7:0]  flags_lo;
	logic        start_seen;
	logic        version_seen;
	logic [15:0] hdr_crc;
	logic [15:0] rx_crc;
	logic [15:0] counter_val;
	logic [31:0] client_val;
	logic [15:0] data_id_val;
	logic [15:0] segments_val;

	res_t        expected_results [$];
	logic [7:0]  frame_buf [$];
	int unsigned bytes_sent  = 0;
	int unsigned error_count = 0;
	logic        steady      = 1'b0;   // no gaps on either side while set

	transport_frame_header_checker i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// CRC-16, MSB first, bit at a time
	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ data[i];
			c  = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic int unsigned opt_bytes(input logic [7:0] f);
		return 2 * f[0] + 4 * f[3] + 2 * f[5] + 2 * f[6];
	endfunction

	// Append one byte to the frame under construction
	function automatic void add_byte(input logic [7:0] b);
		frame_buf.insert(frame_buf.size(), b);
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	task automatic clear_frame_state();
		rx_pos       = '0;
		hdr_len      = '0;
		pay_len      = '0;
		proto        = '0;
		flags_lo     = '0;
		start_seen   = 1'b0;
		version_seen = 1'b0;
		hdr_crc      = CRC_INIT;
		rx_crc       = '0;
		counter_val  = '0;
		client_val   = '0;
		data_id_val  = '0;
		segments_val = '0;
	endtask

	// Advance the parser by one byte and queue the results it implies
	task automatic predict_byte(input logic [7:0] b, input logic fin);
		int unsigned p;
		int unsigned hl;
		int unsigned off;
		int unsigned len;
		res_t        r;
		status_t     st;
		logic        seg;
		p  = rx_pos;
		hl = hdr_len;

		// fixed header
		if (p == 0 && b == START_BYTE) start_seen = 1'b1;
		if (p == 1 && b == VERSION_ONE) version_seen = 1'b1;
		if (p == 2) begin
			hdr_len = b;
			hl      = b;
		end
		if (p == 3) pay_len = {b, 8'h00};
		if (p == 4) pay_len[7:0] = b;
		if (p == 5) proto = b;
		if (p == 9) flags_lo = b;

		// optional fields follow the flags in fixed order
		if (p >= OPT_BASE && p < OPT_END) begin
			off = OPT_BASE;
			if (flags_lo[0]) begin
				if (p >= off && p < off + 2) counter_val = {counter_val[7:0], b};
				off += 2;
			end
			if (flags_lo[3]) begin
				if (p >= off && p < off + 4) client_val = {client_val[23:0], b};
				off += 4;
			end
			if (flags_lo[5]) begin
				if (p >= off && p < off + 2) data_id_val = {data_id_val[7:0], b};
				off += 2;
			end
			if (flags_lo[6]) begin
				if (p >= off && p < off + 2) segments_val = {segments_val[7:0], b};
			end
		end

		// header CRC: first three bytes always count
		if (p < 3 || p + 2 < hl) begin
			hdr_crc = crc16_next(hdr_crc, b);
		end else if (p + 2 == hl) begin
			rx_crc = {b, 8'h00};
		end else if (p + 1 == hl) begin
			rx_crc[7:0] = b;
		end

		// payload window
		if (p >= 12 && start_seen && version_seen && hl == 12 + opt_bytes(flags_lo)
			&& p >= hl && p < hl + pay_len) begin
			r              = '0;
			r.kind         = KIND_PAYLOAD;
			r.payload_byte = b;
			expected_results.insert(expected_results.size(), r);
		end

		if (rx_pos != POS_MAX) rx_pos = rx_pos + 1'b1;

		if (fin) begin
			len = p + 1;
			seg = flags_lo[6];
			if (len < 12) st = ST_SHORT;
			else if (!start_seen) st = ST_START;
			else if (!version_seen) st = ST_VERSION;
			else if (hl != 12 + opt_bytes(flags_lo)) st = ST_HDRLEN;
			else if (len != hl + pay_len + (flags_lo[2] ? 0 : 2)) st = ST_SIZE;
			else if (rx_crc != hdr_crc) st = ST_CRC;
			else if (seg && !flags_lo[5]) st = ST_SEG_NO_ID;
			else if (seg && !flags_lo[0]) st = ST_SEG_NO_CNT;
			else st = ST_OK;

			r        = '0;
			r.kind   = KIND_VERDICT;
			r.status = st;
			r.last   = 1'b1;
			if (st == ST_OK) begin
				r.app_protocol     = proto;
				r.present_mask     = {flags_lo[6], flags_lo[5], flags_lo[3], flags_lo[0]};
				r.message_counter  = counter_val;
				r.source_client_id = client_val;
				r.data_id          = data_id_val;
				r.segment_count    = segments_val;
				r.payload_len      = pay_len;
			end
			expected_results.insert(expected_results.size(), r);
			clear_frame_state();
		end
	endtask

	// Present one byte, with random gaps ahead of it, and wait for the transaction
	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (!steady) begin
			while ($urandom_range(99) < 37) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		predict_byte(b, fin);
		bytes_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++) begin
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		end
	endtask

	// Fill frame_buf with a well-formed frame for the given flags byte and payload size
	task automatic build_frame(input logic [7:0] flags, input int unsigned pl);
		int unsigned hl;
		logic [15:0] crc;
		hl = 12 + opt_bytes(flags);
		frame_buf.delete();
		add_byte(START_BYTE);
		add_byte(VERSION_ONE);
		add_byte(hl[7:0]);
		add_byte(pl[15:8]);
		add_byte(pl[7:0]);
		add_byte(rand_byte());
		repeat (3) add_byte(rand_byte());
		add_byte(flags);
		while (frame_buf.size() < hl - 2) add_byte(rand_byte());
		crc = CRC_INIT;
		foreach (frame_buf[i]) crc = crc16_next(crc, frame_buf[i]);
		add_byte(crc[15:8]);
		add_byte(crc[7:0]);
		repeat (pl) add_byte(rand_byte());
		if (!flags[2]) repeat (2) add_byte(rand_byte());
	endtask

	// Output side: random backpressure
	always @(posedge clk) begin
		m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 37);
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			error_count++;
		end
	endtask

	// Compare every output transaction with the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: kind %0d, tdata %h", m_tuser, m_tdata);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("kind", want.kind, m_tuser);
				check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
				check_field("status", want.status, m_tdata[11:8]);
				check_field("app_protocol", want.app_protocol, m_tdata[19:12]);
				check_field("present_mask", want.present_mask, m_tdata[23:20]);
				check_field("message_counter", want.message_counter, m_tdata[39:24]);
				check_field("source_client_id", want.source_client_id, m_tdata[71:40]);
				check_field("data_id", want.data_id, m_tdata[87:72]);
				check_field("segment_count", want.segment_count, m_tdata[103:88]);
				check_field("payload_len", want.payload_len, m_tdata[119:104]);
				check_field("last", want.last, m_tlast);
			end
		end
	end

	// A frame with no optional fields and no payload, and one carrying every optional field
	task automatic test_minimal_frames();
		build_frame(8'h00, 0);
		send_frame();
		build_frame(8'h69, 3);
		send_frame();
	endtask

	// One frame for each rejection reason
	task automatic test_rejections();
		frame_buf.delete();
		repeat (7) add_byte(rand_byte());
		send_frame();                                  // too short
		build_frame(8'h00, 0);
		frame_buf[0] = 8'h7F;
		send_frame();                                  // bad start byte
		build_frame(8'h00, 0);
		frame_buf[1] = 8'h02;
		send_frame();                                  // bad version
		build_frame(8'h01, 0);
		frame_buf[2] = 8'd12;
		send_frame();                                  // header length vs flags
		build_frame(8'h00, 1);
		void'(frame_buf.pop_back());
		send_frame();                                  // size
		build_frame(8'h00, 0);
		frame_buf[11] = frame_buf[11] ^ 8'h01;
		send_frame();                                  // header CRC
		build_frame(8'h41, 0);
		send_frame();                                  // segmented, no data id
		build_frame(8'h60, 0);
		send_frame();                                  // segmented, no counter
	endtask

	// Payload CRC skipped: the final byte is a payload byte and gives two results
	task automatic test_payload_on_final_byte();
		build_frame(8'h04, 2);
		send_frame();
		build_frame(8'hFF, 1);
		send_frame();
	endtask

	// Header length below the minimum: CRC still runs over the first bytes
	task automatic test_short_header_length();
		build_frame(8'h00, 0);
		frame_buf[2] = 8'd3;
		send_frame();
		build_frame(8'h00, 0);
		frame_buf[2] = 8'd0;
		send_frame();
	endtask

	// Largest announced payload length with all optional fields, cut short, no gaps
	task automatic test_max_payload();
		steady = 1'b1;
		build_frame(8'h6D, 16'hFFFF);
		while (frame_buf.size() > 60) void'(frame_buf.pop_back());
		send_frame();
		steady = 1'b0;
	endtask

	// Mostly well-formed frames with random content, some broken ones and noise
	task automatic test_random_frames();
		int unsigned start_count;
		int unsigned roll;
		int unsigned pl;
		int unsigned idx;
		start_count = bytes_sent;
		while (bytes_sent - start_count < 1400) begin
			roll = $urandom_range(99);
			pl   = ($urandom_range(9) == 0) ? $urandom_range(300, 25) : $urandom_range(24);
			build_frame(rand_byte(), pl);
			if (roll >= 70 && roll < 80) begin
				idx = $urandom_range(frame_buf.size() - 1);
				frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(255, 1));
			end else if (roll >= 80 && roll < 87) begin
				idx = $urandom_range(frame_buf.size() - 1, 1);
				while (frame_buf.size() > idx) void'(frame_buf.pop_back());
			end else if (roll >= 87 && roll < 93) begin
				repeat ($urandom_range(4, 1)) add_byte(rand_byte());
			end else if (roll >= 93) begin
				frame_buf.delete();
				repeat ($urandom_range(30, 1)) add_byte(rand_byte());
				if ($urandom_range(1) && frame_buf.size() > 1) begin
					frame_buf[0] = START_BYTE;
					frame_buf[1] = VERSION_ONE;
				end
			end
			// a stretch without gaps partway through
			steady = (bytes_sent - start_count >= 600 && bytes_sent - start_count < 900);
			send_frame();
		end
		steady = 1'b0;
	endtask

	initial begin
		clear_frame_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_minimal_frames();
		test_rejections();
		test_payload_on_final_byte();
		test_short_header_length();
		test_max_payload();
		test_random_frames();

		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tfhc_pkg.sv
rtl/core/tfhc_parser.sv
rtl/core/tfhc_res_queue.sv
rtl/core/transport_frame_header_checker.sv
bench/transport_frame_header_checker_tb.sv
